// ----- hdl/sdes_ctr_pkg.sv -----
// Shared types, permutation tables and S-DES round functions for the CTR byte cipher.
package sdes_ctr_pkg;

   // Field and register widths
   localparam int unsigned KEY_W     = 10;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned HALF_W    = 5;
   localparam int unsigned NIBBLE_W  = 4;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 10;

   // Register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_CIPHER_KEY      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_COUNTER = 1'b1;

   // Permutation tables, 1-based positions counted from the MSB
   localparam int unsigned P10_TAB   [10] = '{3, 5, 2, 7, 4, 10, 1, 9, 8, 6};
   localparam int unsigned P8_TAB    [8]  = '{6, 3, 7, 4, 8, 5, 10, 9};
   localparam int unsigned IP_TAB    [8]  = '{2, 6, 3, 1, 4, 8, 5, 7};
   localparam int unsigned IPINV_TAB [8]  = '{4, 1, 3, 5, 7, 2, 8, 6};
   localparam int unsigned EP_TAB    [8]  = '{4, 1, 2, 3, 2, 3, 4, 1};
   localparam int unsigned P4_TAB    [4]  = '{2, 4, 3, 1};

   // S-boxes, indexed [row][column]
   localparam logic [1:0] SBOX0_TAB [4][4] = '{
      '{2'd1, 2'd0, 2'd3, 2'd2}, '{2'd3, 2'd2, 2'd1, 2'd0},
      '{2'd0, 2'd2, 2'd1, 2'd3}, '{2'd3, 2'd1, 2'd3, 2'd2}};
   localparam logic [1:0] SBOX1_TAB [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd2, 2'd0, 2'd1, 2'd3},
      '{2'd3, 2'd0, 2'd1, 2'd0}, '{2'd2, 2'd1, 2'd0, 2'd3}};

   // Round subkey pair handed from the register block to the datapath
   typedef struct packed {
      logic [BYTE_W-1:0] sk1;
      logic [BYTE_W-1:0] sk2;
   } subkeys_type;

   function automatic logic [KEY_W-1:0] perm_p10(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] p;
      for (int i = 0; i < 10; i++) p[9-i] = k[10-P10_TAB[i]];
      return p;
   endfunction

   function automatic logic [BYTE_W-1:0] perm_p8(input logic [KEY_W-1:0] k);
      logic [BYTE_W-1:0] p;
      for (int i = 0; i < 8; i++) p[7-i] = k[10-P8_TAB[i]];
      return p;
   endfunction

   function automatic logic [BYTE_W-1:0] perm_ip(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] p;
      for (int i = 0; i < 8; i++) p[7-i] = b[8-IP_TAB[i]];
      return p;
   endfunction

   function automatic logic [BYTE_W-1:0] perm_ipinv(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] p;
      for (int i = 0; i < 8; i++) p[7-i] = b[8-IPINV_TAB[i]];
      return p;
   endfunction

   function automatic logic [BYTE_W-1:0] expand_ep(input logic [NIBBLE_W-1:0] h);
      logic [BYTE_W-1:0] p;
      for (int i = 0; i < 8; i++) p[7-i] = h[4-EP_TAB[i]];
      return p;
   endfunction

   function automatic logic [NIBBLE_W-1:0] perm_p4(input logic [NIBBLE_W-1:0] h);
      logic [NIBBLE_W-1:0] p;
      for (int i = 0; i < 4; i++) p[3-i] = h[4-P4_TAB[i]];
      return p;
   endfunction

   // Key schedule: P10, rotate halves by 1 for K1, by 2 more for K2
   function automatic subkeys_type make_subkeys(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0]  p;
      logic [HALF_W-1:0] hi1, lo1, hi2, lo2;
      subkeys_type       s;
      p   = perm_p10(key);
      hi1 = {p[8:5], p[9]};
      lo1 = {p[3:0], p[4]};
      hi2 = {hi1[2:0], hi1[4:3]};
      lo2 = {lo1[2:0], lo1[4:3]};
      s.sk1 = perm_p8({hi1, lo1});
      s.sk2 = perm_p8({hi2, lo2});
      return s;
   endfunction

   // Round function f_k: expand, mix key, two S-box lookups, P4
   function automatic logic [NIBBLE_W-1:0] round_fk(input logic [NIBBLE_W-1:0] half,
                                                   input logic [BYTE_W-1:0] sk);
      logic [BYTE_W-1:0]   x;
      logic [NIBBLE_W-1:0] a, b;
      logic [1:0]          s0, s1;
      x  = expand_ep(half) ^ sk;
      a  = x[7:4];
      b  = x[3:0];
      s0 = SBOX0_TAB[{a[3], a[0]}][a[2:1]];
      s1 = SBOX1_TAB[{b[3], b[0]}][b[2:1]];
      return perm_p4({s0, s1});
   endfunction

endpackage

// ----- hdl/sdes_ctr_stream_cipher_top.sv -----
// Top level of the S-DES counter-mode byte stream cipher.
// Each accepted word is XORed with the S-DES encryption of an 8-bit running counter that
// wraps modulo 256; the same operation encrypts and decrypts. Setting req_tuser (restart)
// on a word reloads the counter from the initial_counter register before that word is
// processed. The block takes one word per clock while rsp_tready is high: a word is
// registered on input, the keystream is formed combinationally from that register, and the
// result sits in an output register, so a result word passes through the input register
// and then the output register before it is offered.
// Write cipher_key (index 0) and initial_counter (index 1) only while no word is in flight.
module sdes_ctr_stream_cipher_top import sdes_ctr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // input channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [BYTE_W-1:0]    req_tdata,   // [7:0] data_in
   input  logic                 req_tuser,   // [0] restart
   // result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [BYTE_W-1:0]    rsp_tdata,   // [7:0] data_out
   // configuration write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   subkeys_type       subkeys;
   logic [BYTE_W-1:0] init_ctr;
   logic [BYTE_W-1:0] keystream;

   logic [BYTE_W-1:0] counter_ff,   counter_in;
   logic              s1_valid_ff,  s1_valid_in;
   logic [BYTE_W-1:0] s1_data_ff,   s1_data_in;
   logic [BYTE_W-1:0] s1_ctr_ff,    s1_ctr_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_data_ff,  out_data_in;

   logic              out_free;
   logic              s1_move;
   logic              req_take;
   logic [BYTE_W-1:0] ctr_use;

   sdes_ctr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .subkeys   (subkeys),
      .init_ctr  (init_ctr)
   );

   sdes_ctr_enc u_enc (
      .subkeys   (subkeys),
      .block_in  (s1_ctr_ff),
      .block_out (keystream)
   );

   // Handshake: each stage advances when the one after it is free
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   // Counter to use for this word, restart takes priority
   assign ctr_use = req_tuser ? init_ctr : counter_ff;

   always_comb begin
      counter_in   = counter_ff;
      s1_valid_in  = s1_valid_ff;
      s1_data_in   = s1_data_ff;
      s1_ctr_in    = s1_ctr_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;

      // input stage
      if (req_take) begin
         counter_in   = ctr_use + 8'd1;
         s1_valid_in  = 1'b1;
         s1_data_in   = req_tdata;
         s1_ctr_in    = ctr_use;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      // result stage
      if (s1_move) begin
         out_valid_in = 1'b1;
         out_data_in  = s1_data_ff ^ keystream;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         counter_ff   <= counter_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      s1_ctr_ff   <= s1_ctr_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ----- hdl/sdes_ctr_csr.sv -----
// Configuration registers: cipher key with derived subkeys, and initial counter.
module sdes_ctr_csr import sdes_ctr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   output subkeys_type          subkeys,
   output logic [BYTE_W-1:0]    init_ctr
);

   logic [KEY_W-1:0]  key_ff,  key_in;
   logic [BYTE_W-1:0] ictr_ff, ictr_in;

   assign csr_ready = 1'b1;

   // Register write decode
   always_comb begin
      key_in  = key_ff;
      ictr_in = ictr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_CIPHER_KEY:      key_in  = csr_data[KEY_W-1:0];
            REG_INITIAL_COUNTER: ictr_in = csr_data[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         ictr_ff <= '0;
      end else begin
         key_ff  <= key_in;
         ictr_ff <= ictr_in;
      end
   end

   // Subkeys are fixed wiring of the key
   assign subkeys  = make_subkeys(key_ff);
   assign init_ctr = ictr_ff;

endmodule

// ----- hdl/sdes_ctr_enc.sv -----
// Two-round S-DES encryption of one counter block, purely combinational.
module sdes_ctr_enc import sdes_ctr_pkg::*; (
   input  subkeys_type       subkeys,
   input  logic [BYTE_W-1:0] block_in,
   output logic [BYTE_W-1:0] block_out
);

   logic [BYTE_W-1:0]   ip_out;
   logic [NIBBLE_W-1:0] l0, r0, r1, l2;

   // IP, f_k with K1, swap, f_k with K2, IP inverse
   always_comb begin
      ip_out    = perm_ip(block_in);
      l0        = ip_out[7:4];
      r0        = ip_out[3:0];
      r1        = l0 ^ round_fk(r0, subkeys.sk1);
      l2        = r0 ^ round_fk(r1, subkeys.sk2);
      block_out = perm_ipinv({l2, r1});
   end

endmodule

// ----- tb/sdes_ctr_stream_cipher_top_tb.sv -----
// Self-checking testbench for the S-DES counter-mode byte stream cipher.
module sdes_ctr_stream_cipher_top_tb;
   import sdes_ctr_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned MAX_SHOWN   = 10;
   localparam int unsigned SETTLE      = 4;

   // Bit positions, 1-based from the MSB; short lists padded with zeros
   typedef int unsigned perm_list_type [10];
   localparam perm_list_type PERM_P10   = '{3, 5, 2, 7, 4, 10, 1, 9, 8, 6};
   localparam perm_list_type PERM_P8    = '{6, 3, 7, 4, 8, 5, 10, 9, 0, 0};
   localparam perm_list_type PERM_IP    = '{2, 6, 3, 1, 4, 8, 5, 7, 0, 0};
   localparam perm_list_type PERM_IPINV = '{4, 1, 3, 5, 7, 2, 8, 6, 0, 0};
   localparam perm_list_type PERM_EP    = '{4, 1, 2, 3, 2, 3, 4, 1, 0, 0};
   localparam perm_list_type PERM_P4    = '{2, 4, 3, 1, 0, 0, 0, 0, 0, 0};

   // S-boxes flattened, indexed by {row, column}
   localparam logic [1:0] SBOX_LEFT [16] = '{
      2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0,
      2'd0, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd3, 2'd2};
   localparam logic [1:0] SBOX_RIGHT [16] = '{
      2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
      2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [BYTE_W-1:0]    req_tdata;   // [7:0] data_in
   logic                 req_tuser;   // [0] restart
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [BYTE_W-1:0]    rsp_tdata;   // [7:0] data_out
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   // Shadow state of the cipher
   logic [KEY_W-1:0]  key_shadow;
   logic [BYTE_W-1:0] ctr_start_shadow;
   logic [BYTE_W-1:0] counter_shadow;
   logic [BYTE_W-1:0] expected_bytes [$];

   int unsigned req_idle_pct;
   int unsigned rsp_stall_pct;
   logic        hold_active;
   event        rsp_hold_ev;
   int unsigned fail_count;
   int unsigned cycle_count;

   sdes_ctr_stream_cipher_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // ---------------------------------------------------------------- prediction

   // Gather bits of a width-bit word by MSB-relative position
   function automatic logic [9:0] select_bits(input logic [9:0] word, input int unsigned width,
                                              input perm_list_type pos,
                                              input int unsigned count);
      logic [9:0] acc;
      acc = '0;
      for (int i = 0; i < count; i++) acc = {acc[8:0], word[width - pos[i]]};
      return acc;
   endfunction

   function automatic logic [3:0] round_mix(input logic [3:0] half, input logic [7:0] sk);
      logic [9:0] wide;
      logic [7:0] x;
      logic [1:0] s0, s1;
      wide = select_bits({6'b0, half}, 4, PERM_EP, 8);
      x    = wide[7:0] ^ sk;
      s0   = SBOX_LEFT[{x[7], x[4], x[6:5]}];
      s1   = SBOX_RIGHT[{x[3], x[0], x[2:1]}];
      wide = select_bits({6'b0, s0, s1}, 4, PERM_P4, 4);
      return wide[3:0];
   endfunction

   // Keystream byte for one counter value, XORed onto the data byte
   function automatic logic [7:0] cipher_byte_predict(input logic [9:0] key,
                                                      input logic [7:0] ctr,
                                                      input logic [7:0] data);
      logic [9:0] p, sk1, sk2, t, ks;
      logic [4:0] hi, lo;
      logic [3:0] l1, r1, l2;
      p   = select_bits(key, 10, PERM_P10, 10);
      hi  = {p[8:5], p[9]};
      lo  = {p[3:0], p[4]};
      sk1 = select_bits({hi, lo}, 10, PERM_P8, 8);
      hi  = {hi[2:0], hi[4:3]};
      lo  = {lo[2:0], lo[4:3]};
      sk2 = select_bits({hi, lo}, 10, PERM_P8, 8);
      t   = select_bits({2'b0, ctr}, 8, PERM_IP, 8);
      l1  = t[3:0];
      r1  = t[7:4] ^ round_mix(t[3:0], sk1[7:0]);
      l2  = l1 ^ round_mix(r1, sk2[7:0]);
      ks  = select_bits({2'b0, l2, r1}, 8, PERM_IPINV, 8);
      return data ^ ks[7:0];
   endfunction

   task automatic note_mismatch(input string what, input logic [7:0] exp_v,
                                input logic [7:0] act_v);
      if (fail_count < MAX_SHOWN)
         $display("[%0d] %s: expected %02h, got %02h", cycle_count, what, exp_v, act_v);
      fail_count++;
   endtask

   // Track config writes and accepted words, check each result word
   always @(posedge clock) begin
      if (reset) begin
         key_shadow       = '0;
         ctr_start_shadow = '0;
         counter_shadow   = '0;
         expected_bytes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CIPHER_KEY:      key_shadow = csr_data[KEY_W-1:0];
               REG_INITIAL_COUNTER: ctr_start_shadow = csr_data[BYTE_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser) counter_shadow = ctr_start_shadow;
            expected_bytes.push_back(cipher_byte_predict(key_shadow, counter_shadow, req_tdata));
            counter_shadow = counter_shadow + 8'd1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0)
               note_mismatch("unexpected result word", 8'h00, rsp_tdata);
            else if (expected_bytes[0] !== rsp_tdata)
               note_mismatch("data_out", expected_bytes.pop_front(), rsp_tdata);
            else
               void'(expected_bytes.pop_front());
         end
      end
   end

   // Timeout guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- receiver side

   initial begin
      forever begin
         @(negedge clock);
         rsp_tready = hold_active ? 1'b0 : ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Long hold-off, counted here so the sender keeps pushing meanwhile
   initial begin
      forever begin
         @(rsp_hold_ev);
         hold_active = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active = 1'b0;
      end
   end

   // ---------------------------------------------------------------- sender side

   // Offer one word and return at the edge that takes it
   task automatic send_word(input logic [7:0] data, input logic restart);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid = 1'b0;
         req_tdata  = 8'($urandom);
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = data;
      req_tuser  = restart;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering and wait until every result word is back
   task automatic drain;
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      drain();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // Reset values: key 0, counter counting up from 0
   task automatic test_reset_state;
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'hA5, 1'b0);
      send_word(8'h5A, 1'b1);
   endtask

   // All-ones key and start counter; upper data bits of the counter write are dropped
   task automatic test_extreme_config;
      write_csr(REG_CIPHER_KEY, 10'h3FF);
      write_csr(REG_INITIAL_COUNTER, 10'h3FF);
      send_word(8'h00, 1'b1);
      send_word(8'hFF, 1'b0);
      send_word(8'h81, 1'b0);
      send_word(8'h3C, 1'b1);
      send_word(8'h7E, 1'b0);
   endtask

   // Counter wraps from 255 to 0; restart on back-to-back words
   task automatic test_counter_wrap;
      write_csr(REG_CIPHER_KEY, 10'h282);
      write_csr(REG_INITIAL_COUNTER, 10'h0FC);
      send_word(8'h12, 1'b1);
      for (int i = 0; i < 6; i++) send_word(8'($urandom), 1'b0);
      send_word(8'h55, 1'b1);
      send_word(8'hAA, 1'b1);
      write_csr(REG_CIPHER_KEY, 10'h000);
      write_csr(REG_INITIAL_COUNTER, 10'h100);
      send_word(8'hC3, 1'b1);
   endtask

   // Receiver stops for a long stretch so the pipeline fills and stalls input
   task automatic test_backpressure_fill;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      drain();
      -> rsp_hold_ev;
      for (int i = 0; i < 40; i++) send_word(8'($urandom), (i == 0));
   endtask

   // Messages of random length, most opened by a restart, with stray restarts
   task automatic test_random_traffic(input int unsigned n_words, input int unsigned idle_pct,
                                      input int unsigned stall_pct);
      int unsigned sent;
      int unsigned msg_left;
      logic [9:0]  key_val;
      sent          = 0;
      msg_left      = 0;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      while (sent < n_words) begin
         if (sent % 150 == 0) begin
            case ($urandom_range(0, 3))
               0:       key_val = 10'h000;
               1:       key_val = 10'h3FF;
               default: key_val = 10'($urandom);
            endcase
            write_csr(REG_CIPHER_KEY, key_val);
            write_csr(REG_INITIAL_COUNTER, 10'($urandom));
            msg_left = 0;
         end
         if (msg_left == 0) begin
            msg_left = $urandom_range(1, 48);
            send_word(8'($urandom), ($urandom_range(0, 9) != 0));
         end else begin
            send_word(8'($urandom), ($urandom_range(0, 15) == 0));
         end
         msg_left--;
         sent++;
      end
   endtask

   // ---------------------------------------------------------------- run

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      rsp_tready    = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = REG_CIPHER_KEY;
      csr_data      = '0;
      hold_active   = 1'b0;
      req_idle_pct  = 0;
      rsp_stall_pct = 30;
      fail_count    = 0;
      cycle_count   = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_extreme_config();
      test_counter_wrap();
      test_backpressure_fill();
      test_random_traffic(450, 12, 71);
      test_random_traffic(450, 71, 12);
      test_random_traffic(450, 0, 0);

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_bytes.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
